### sv/chull_pkg.sv
// Package for the convex hull block: payload structs, front/back job word, FSM states.
// No dependencies.
package chull_pkg;

   localparam int unsigned FIELD_WIDTH = 32;
   localparam logic [15:0] TOL_RESET = 16'd6;
   localparam logic [0:0] ADDR_TOL = 1'b0;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] point_x;
      logic signed [FIELD_WIDTH-1:0] point_z;
      logic                          last_point;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] hull_x;
      logic signed [FIELD_WIDTH-1:0] hull_z;
      logic                          last_vertex;
      logic                          overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DD_RD,
      ST_DD_CMP,
      ST_SMALL,
      ST_H_RD,
      ST_H_MUL,
      ST_H_SUB,
      ST_H_DEC,
      ST_EMIT_RD,
      ST_EMIT
   } back_state_type;

endpackage

### sv/chull_front.sv
// Front end of the convex hull block: takes requests into a two-entry queue.
// Depends on chull_pkg.
module chull_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  chull_pkg::req_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output chull_pkg::req_type head
);

   chull_pkg::req_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;

   always_comb begin
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) begin
         q_ff[wr_ff] <= push_data;
      end
   end

   assign full = cnt_ff[1];
   assign not_empty = cnt_ff != 2'd0;
   assign head = q_ff[rd_ff];

endmodule

### sv/chull_back.sv
// Back end of the convex hull block: sorted store, dedupe, monotone chain, emit.
// Depends on chull_pkg.
module chull_back #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  chull_pkg::req_type job,
   output logic               job_pop,
   input  logic [15:0]        tol,
   output logic               rsp_valid,
   output chull_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int SW = AW + 1;
   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] z;
   } pt_type;

   pt_type ps_mem [MAX_POINTS];
   pt_type hs_mem [2*MAX_POINTS];

   chull_pkg::back_state_type st_ff, st_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [SW-1:0] i_ff, i_in;
   logic [SW-1:0] n_ff, n_in;
   logic [SW:0]   k_ff, k_in;
   logic [SW:0]   lower_ff, lower_in;
   logic          upper_ff, upper_in;
   pt_type        newp_ff, newp_in;
   logic          lastp_ff, lastp_in;
   pt_type        prd_ff, hra_ff, hrb_ff, keep_ff, keep_in;
   logic signed [PW-1:0] m1_ff, m2_ff;
   logic          ps_we;
   logic [AW-1:0] ps_wa, ps_ra;
   pt_type        ps_wd;
   logic          hs_we;
   logic [SW:0]   hs_wa, hs_ra0, hs_ra1;
   pt_type        hs_wd;
   pt_type        p;
   logic          less;
   logic signed [DW-1:0] ax, az, bx, bz, dx, dz;
   logic signed [PW-1:0] cr;
   logic          rv_in;
   chull_pkg::rsp_type rd_in;

   assign p.x = job.point_x[CW-1:0];
   assign p.z = job.point_z[CW-1:0];
   assign less = (newp_ff.x < prd_ff.x) ||
                 ((newp_ff.x == prd_ff.x) && (newp_ff.z < prd_ff.z));

   // dedupe differences: prd is candidate, keep is last kept point
   assign dx = (DW'(prd_ff.x) > DW'(keep_ff.x)) ? DW'(prd_ff.x) - DW'(keep_ff.x)
                                                : DW'(keep_ff.x) - DW'(prd_ff.x);
   assign dz = (DW'(prd_ff.z) > DW'(keep_ff.z)) ? DW'(prd_ff.z) - DW'(keep_ff.z)
                                                : DW'(keep_ff.z) - DW'(prd_ff.z);
   // turn operands: o = hra, a = hrb, b = prd
   assign ax = DW'(hrb_ff.x) - DW'(hra_ff.x);
   assign az = DW'(hrb_ff.z) - DW'(hra_ff.z);
   assign bx = DW'(prd_ff.x) - DW'(hra_ff.x);
   assign bz = DW'(prd_ff.z) - DW'(hra_ff.z);
   assign cr = m1_ff - m2_ff;

   always_ff @(posedge clock) begin
      if (ps_we) begin
         ps_mem[ps_wa] <= ps_wd;
      end
      prd_ff <= ps_mem[ps_ra];
      if (hs_we) begin
         hs_mem[hs_wa[SW-1:0]] <= hs_wd;
      end
      hra_ff <= hs_mem[hs_ra0[SW-1:0]];
      hrb_ff <= hs_mem[hs_ra1[SW-1:0]];
      m1_ff <= PW'(ax) * PW'(bz);
      m2_ff <= PW'(az) * PW'(bx);
   end

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      pos_in = pos_ff;
      i_in = i_ff;
      n_in = n_ff;
      k_in = k_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      newp_in = newp_ff;
      lastp_in = lastp_ff;
      keep_in = keep_ff;
      job_pop = 1'b0;
      ps_we = 1'b0;
      ps_wa = '0;
      ps_wd = newp_ff;
      ps_ra = '0;
      hs_we = 1'b0;
      hs_wa = k_ff;
      hs_wd = prd_ff;
      hs_ra0 = k_ff - (SW+1)'(2);
      hs_ra1 = k_ff - (SW+1)'(1);
      rv_in = 1'b0;
      rd_in = '0;
      case (st_ff)
         chull_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               newp_in = p;
               lastp_in = job.last_point;
               pos_in = cnt_ff;
               if (cnt_ff == SW'(MAX_POINTS)) begin
                  ovf_in = 1'b1;
                  i_in = '0;
                  n_in = '0;
                  st_in = job.last_point ? chull_pkg::ST_DD_RD : chull_pkg::ST_IDLE;
               end else begin
                  st_in = chull_pkg::ST_SCAN;
               end
            end
         end
         chull_pkg::ST_SCAN: begin
            // read entry pos-1
            ps_ra = AW'(pos_ff - SW'(1));
            if (pos_ff == '0) begin
               ps_we = 1'b1;
               ps_wa = '0;
               cnt_in = cnt_ff + SW'(1);
               i_in = '0;
               n_in = '0;
               st_in = lastp_ff ? chull_pkg::ST_DD_RD : chull_pkg::ST_IDLE;
            end else begin
               st_in = chull_pkg::ST_SHIFT;
            end
         end
         chull_pkg::ST_SHIFT: begin
            ps_we = 1'b1;
            if (less) begin
               // move entry up one slot, keep going down
               ps_wa = AW'(pos_ff);
               ps_wd = prd_ff;
               pos_in = pos_ff - SW'(1);
               st_in = chull_pkg::ST_SCAN;
            end else begin
               ps_wa = AW'(pos_ff);
               cnt_in = cnt_ff + SW'(1);
               i_in = '0;
               n_in = '0;
               st_in = lastp_ff ? chull_pkg::ST_DD_RD : chull_pkg::ST_IDLE;
            end
         end
         chull_pkg::ST_DD_RD: begin
            ps_ra = AW'(i_ff);
            if (i_ff == cnt_ff) begin
               i_in = '0;
               k_in = '0;
               upper_in = 1'b0;
               st_in = (n_ff < SW'(3)) ? chull_pkg::ST_SMALL : chull_pkg::ST_H_RD;
            end else begin
               st_in = chull_pkg::ST_DD_CMP;
            end
         end
         chull_pkg::ST_DD_CMP: begin
            if (n_ff != '0 && dx < DW'(tol) && dz < DW'(tol)) begin
               i_in = i_ff + SW'(1);
            end else begin
               ps_we = 1'b1;
               ps_wa = AW'(n_ff);
               ps_wd = prd_ff;
               keep_in = prd_ff;
               n_in = n_ff + SW'(1);
               i_in = i_ff + SW'(1);
            end
            st_in = chull_pkg::ST_DD_RD;
         end
         chull_pkg::ST_SMALL: begin
            // emit directly from the store; prd holds entry i-1 after first pass
            ps_ra = AW'(i_ff);
            if (i_ff != '0) begin
               rv_in = 1'b1;
               rd_in.hull_x = chull_pkg::FIELD_WIDTH'(prd_ff.x);
               rd_in.hull_z = chull_pkg::FIELD_WIDTH'(prd_ff.z);
               rd_in.last_vertex = (i_ff == n_ff);
               rd_in.overflow = ovf_ff;
            end
            if (i_ff == n_ff) begin
               cnt_in = '0;
               ovf_in = 1'b0;
               st_in = chull_pkg::ST_IDLE;
            end else begin
               i_in = i_ff + SW'(1);
            end
         end
         chull_pkg::ST_H_RD: begin
            // lower: point i; upper: point i-1
            ps_ra = upper_ff ? AW'(i_ff - SW'(1)) : AW'(i_ff);
            if (!upper_ff && i_ff == n_ff) begin
               lower_in = k_ff;
               upper_in = 1'b1;
               i_in = n_ff - SW'(1);
            end else if (upper_ff && i_ff == '0) begin
               if (k_ff > (SW+1)'(1)) begin
                  k_in = k_ff - (SW+1)'(1);
               end
               if (k_in > (SW+1)'(MAX_POINTS)) begin
                  k_in = (SW+1)'(MAX_POINTS);
               end
               i_in = '0;
               st_in = chull_pkg::ST_EMIT_RD;
            end else begin
               st_in = chull_pkg::ST_H_MUL;
            end
         end
         chull_pkg::ST_H_MUL: begin
            // hold the candidate point in prd for the push
            ps_ra = upper_ff ? AW'(i_ff - SW'(1)) : AW'(i_ff);
            if (k_ff >= (SW+1)'(2) && (!upper_ff || k_ff > lower_ff)) begin
               st_in = chull_pkg::ST_H_SUB;
            end else begin
               st_in = chull_pkg::ST_H_DEC;
            end
         end
         chull_pkg::ST_H_SUB: begin
            ps_ra = upper_ff ? AW'(i_ff - SW'(1)) : AW'(i_ff);
            st_in = chull_pkg::ST_H_DEC;
            if (cr[PW-1] || cr == '0) begin
               // pop and retest against the new top
               k_in = k_ff - (SW+1)'(1);
               st_in = chull_pkg::ST_H_RD;
               if (upper_ff) begin
                  i_in = i_ff;
               end
            end
         end
         chull_pkg::ST_H_DEC: begin
            hs_we = 1'b1;
            k_in = k_ff + (SW+1)'(1);
            i_in = upper_ff ? i_ff - SW'(1) : i_ff + SW'(1);
            st_in = chull_pkg::ST_H_RD;
         end
         chull_pkg::ST_EMIT_RD: begin
            hs_ra0 = (SW+1)'(i_ff);
            st_in = chull_pkg::ST_EMIT;
         end
         chull_pkg::ST_EMIT: begin
            hs_ra0 = (SW+1)'(i_ff) + (SW+1)'(1);
            rv_in = 1'b1;
            rd_in.hull_x = chull_pkg::FIELD_WIDTH'(hra_ff.x);
            rd_in.hull_z = chull_pkg::FIELD_WIDTH'(hra_ff.z);
            rd_in.last_vertex = ((SW+1)'(i_ff) + (SW+1)'(1) == k_ff);
            rd_in.overflow = ovf_ff;
            i_in = i_ff + SW'(1);
            if (rd_in.last_vertex) begin
               cnt_in = '0;
               ovf_in = 1'b0;
               st_in = chull_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = chull_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= chull_pkg::ST_IDLE;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         rsp_valid <= rv_in;
      end
      pos_ff <= pos_in;
      i_ff <= i_in;
      n_ff <= n_in;
      k_ff <= k_in;
      lower_ff <= lower_in;
      upper_ff <= upper_in;
      newp_ff <= newp_in;
      lastp_ff <= lastp_in;
      keep_ff <= keep_in;
      rsp_data <= rd_in;
   end

endmodule

### sv/convex_hull_2d.sv
// Top level of the 2D convex hull block (monotone chain): CSR, front queue, back end.
// Depends on chull_pkg, chull_front, chull_back.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+----------------------------
//  request  | req_start/req_busy/req_data    | taken when start & !busy
//  result   | rsp_strobe/rsp_data            | one cycle, cannot stall
//  config   | csr_p* (APB)                   | write on psel&penable&pwrite
//
// A non-final point is inserted into the sorted store, moving larger entries up a slot.
// A final point adds a dedupe pass, then a chain pass of pushes and pops on the shared
// cross-product multipliers (none below three points), then emits the vertices.
// Reset is synchronous; the sets start empty and the tolerance is 6.
// busy rises while the two-entry request queue is full.
module convex_hull_2d #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  chull_pkg::req_type req_data,
   output logic               rsp_strobe,
   output chull_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [0:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [15:0] tol_ff;
   logic        q_full, q_ne, q_pop;
   chull_pkg::req_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= chull_pkg::TOL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == chull_pkg::ADDR_TOL) begin
         tol_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == chull_pkg::ADDR_TOL) ? {16'd0, tol_ff} : 32'd0;
   assign req_busy = q_full;

   chull_front u_front (
      .clock(clock), .reset(reset),
      .push(req_start && !q_full), .push_data(req_data),
      .pop(q_pop), .full(q_full), .not_empty(q_ne), .head(q_head)
   );

   chull_back #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_ne), .job(q_head), .job_pop(q_pop), .tol(tol_ff),
      .rsp_valid(rsp_strobe), .rsp_data(rsp_data)
   );

endmodule

### sv/convex_hull_2d_checker.sv
// Port checker for convex_hull_2d, bound to the top level.
// Depends on chull_pkg.
module convex_hull_2d_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_busy,
   input logic               rsp_strobe,
   input chull_pkg::rsp_type rsp_data,
   input logic               csr_pready
);

   a_ready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
   a_quiet_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_strobe)
      else $error("result right after reset");
   a_not_busy_reset: assert property (@(posedge clock) $past(reset) |-> !req_busy)
      else $error("busy right after reset");
   a_ovf_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_vertex ##1 rsp_strobe |-> $stable(rsp_data.overflow))
      else $error("overflow changed within a set");

endmodule

bind convex_hull_2d convex_hull_2d_checker u_chk (
   .clock(clock), .reset(reset), .req_busy(req_busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_pready(csr_pready)
);

### bench/testbench.sv
// Self-checking bench for convex_hull_2d: random point sets in, hull vertices checked.
// Depends on chull_pkg and the convex_hull_2d RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS = 64;

   typedef struct {
      longint x;
      longint z;
   } point_type;

   logic clock, reset;
   logic req_start;
   logic req_busy;
   chull_pkg::req_type req_data;
   logic rsp_strobe;
   chull_pkg::rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [0:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   convex_hull_2d u_top (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hull predictor state
   point_type sorted_pts[NPTS];
   point_type chain[2*NPTS];
   int stored_count;
   bit overflow_flag;
   int unsigned tolerance;

   chull_pkg::req_type pending_reqs[$];
   chull_pkg::rsp_type hull_expect[$];
   int errors, mismatches, vertices_seen, sets_closed, idle_cycles;
   bit driving_done;

   function automatic bit pt_less(point_type a, point_type b);
      return a.x < b.x || (a.x == b.x && a.z < b.z);
   endfunction

   // cross product fits comfortably in 128-bit signed math
   function automatic bit not_left(point_type o, point_type a, point_type b);
      logic signed [127:0] c;
      c = 128'(a.x - o.x) * 128'(b.z - o.z) - 128'(a.z - o.z) * 128'(b.x - o.x);
      return c <= 0;
   endfunction

   function automatic longint adiff(longint a, longint b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic void push_vertex(point_type p, bit lastv);
      chull_pkg::rsp_type r;
      r.hull_x = p.x[31:0];
      r.hull_z = p.z[31:0];
      r.last_vertex = lastv;
      r.overflow = overflow_flag;
      hull_expect = {hull_expect, r};
   endfunction

   function automatic void predict_hull(chull_pkg::req_type q);
      point_type p;
      int pos, n, k, lower;
      p.x = longint'(q.point_x);
      p.z = longint'(q.point_z);
      if (stored_count < NPTS) begin
         pos = stored_count;
         while (pos > 0 && pt_less(p, sorted_pts[pos-1])) begin
            sorted_pts[pos] = sorted_pts[pos-1];
            pos--;
         end
         sorted_pts[pos] = p;
         stored_count++;
      end else begin
         overflow_flag = 1'b1;
      end
      if (!q.last_point) return;
      sets_closed++;
      n = 0;
      for (int i = 0; i < stored_count; i++) begin
         if (n > 0 && adiff(sorted_pts[i].x, sorted_pts[n-1].x) < tolerance
             && adiff(sorted_pts[i].z, sorted_pts[n-1].z) < tolerance)
            continue;
         sorted_pts[n++] = sorted_pts[i];
      end
      if (n < 3) begin
         for (int i = 0; i < n; i++) push_vertex(sorted_pts[i], i + 1 == n);
      end else begin
         k = 0;
         for (int i = 0; i < n; i++) begin
            while (k >= 2 && not_left(chain[k-2], chain[k-1], sorted_pts[i])) k--;
            chain[k++] = sorted_pts[i];
         end
         lower = k;
         for (int i = n - 1; i > 0; i--) begin
            while (k > lower && not_left(chain[k-2], chain[k-1], sorted_pts[i-1])) k--;
            chain[k++] = sorted_pts[i-1];
         end
         if (k > 1) k--;
         if (k > NPTS) k = NPTS;
         for (int i = 0; i < k; i++) push_vertex(chain[i], i + 1 == k);
      end
      stored_count = 0;
      overflow_flag = 1'b0;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
         gap_left <= 0;
      end else if (req_start && req_busy) begin
         // hold until accepted
      end else begin
         if (req_start) predict_hull(req_data);
         if (req_start && gap_left == 0 && pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            gap_left <= gap_len();
         end else if (gap_left > 0) begin
            req_start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_reqs.size() > 0) begin
            req_start <= 1'b1;
            req_data <= pending_reqs.pop_front();
            gap_left <= gap_len();
         end else begin
            req_start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      chull_pkg::rsp_type e;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            vertices_seen++;
            if (hull_expect.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected vertex %p", rsp_data);
            end else begin
               e = hull_expect.pop_front();
               if (e !== rsp_data) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("vertex mismatch: expected %p, got %p", e, rsp_data);
               end
            end
         end
         if (rsp_strobe || (req_start && !req_busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 200000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_start || hull_expect.size() > 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_tolerance(int unsigned v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= chull_pkg::ADDR_TOL;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      tolerance = v & 16'hffff;
      @(posedge clock);
   endtask

   function automatic void add_point(logic [31:0] x, logic [31:0] z, bit lastp);
      chull_pkg::req_type q;
      q.point_x = x;
      q.point_z = z;
      q.last_point = lastp;
      pending_reqs = {pending_reqs, q};
   endfunction

   // well-formed set; clustered coordinates make duplicates and collinear runs likely
   function automatic void add_random_set(int npts);
      int mode;
      logic [31:0] x, z;
      mode = $urandom_range(0, 3);
      for (int i = 0; i < npts; i++) begin
         case (mode)
            0: begin x = $urandom; z = $urandom; end
            1: begin x = $urandom_range(0, 20) - 10; z = $urandom_range(0, 20) - 10; end
            2: begin x = $urandom_range(0, 1000); z = 3 * x + 7; end
            default: begin x = $urandom_range(0, 60) << 16; z = $urandom_range(0, 60) << 16; end
         endcase
         add_point(x, z, i == npts - 1);
      end
   endfunction

   initial begin
      int total, len;
      int unsigned tol_choices[4] = '{0, 1, 100, 65535};
      reset = 1'b1;
      req_start = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      tolerance = 6;
      stored_count = 0;
      overflow_flag = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single point, extremes, pair, collinear, square, duplicates
      add_point(32'h7fffffff, 32'h80000000, 1'b1);
      add_point(32'h80000000, 32'h7fffffff, 1'b0);
      add_point(32'h7fffffff, 32'h80000000, 1'b1);
      add_point(0, 0, 1'b0);
      add_point(10, 10, 1'b0);
      add_point(20, 20, 1'b1);
      add_point(32'h80000000, 32'h80000000, 1'b0);
      add_point(32'h7fffffff, 32'h80000000, 1'b0);
      add_point(32'h7fffffff, 32'h7fffffff, 1'b0);
      add_point(32'h80000000, 32'h7fffffff, 1'b0);
      add_point(0, 0, 1'b1);
      add_point(100, 100, 1'b0);
      add_point(103, 98, 1'b0);
      add_point(200, 100, 1'b0);
      add_point(150, 300, 1'b1);
      wait_drained();

      // overflow: 70 points into a 64-entry store
      write_tolerance(0);
      add_random_set(70);
      wait_drained();

      total = 0;
      while (total < 360) begin
         write_tolerance(tol_choices[$urandom_range(0, 3)]);
         for (int s = 0; s < 6; s++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 10);
            add_random_set(len);
            total += len;
         end
         wait_drained();
      end
      write_tolerance(6);
      add_random_set(5);
      wait_drained();

      $display("%0d point sets closed, %0d hull vertices checked, %0d mismatches",
               sets_closed, vertices_seen, mismatches);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
